### rtl/tcl_pkg.sv
// Shared types, character codes, token classes and keyword tables for the token classifier.
package tcl_pkg;

    localparam int unsigned NKW    = 18;
    localparam int unsigned KW_MAX = 9;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic [3:0] token_class;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] word_length;
        logic [4:0] keyword_index;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_core_out;

    localparam logic [3:0] CLS_RESERVED   = 4'd0;
    localparam logic [3:0] CLS_NUMBER     = 4'd1;
    localparam logic [3:0] CLS_STRING     = 4'd2;
    localparam logic [3:0] CLS_IDENTIFIER = 4'd3;
    localparam logic [3:0] CLS_INVALID    = 4'd4;
    localparam logic [3:0] CLS_OPERATOR   = 4'd5;
    localparam logic [3:0] CLS_SPECIAL    = 4'd6;
    localparam logic [3:0] CLS_RELATIONAL = 4'd7;
    localparam logic [3:0] CLS_ASSIGN     = 4'd8;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    // Keyword text is right-justified: the last character sits in the low byte.
    localparam logic [KW_MAX*8-1:0] KW_TEXT [NKW] = '{
        "if", "then", "else", "case", "or", "and", "for", "end", "in",
        "begin", "float", "double", "int", {"long", "_int"}, "char", "string",
        {"short", "_int"}, "bool"
    };

    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd3, 4'd3, 4'd3, 4'd2,
        4'd5, 4'd5, 4'd6, 4'd3, 4'd8, 4'd4, 4'd6, 4'd9, 4'd4
    };

    function automatic logic [7:0] kw_char(input logic [KW_MAX*8-1:0] text,
                                           input logic [3:0] len,
                                           input logic [3:0] pos);
        logic [3:0] idx;
        idx = len - pos - 4'd1;
        kw_char = (pos < len) ? text[{idx, 3'b000} +: 8] : 8'h00;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        is_symbol = (c == CH_SPACE) || (c == CH_PLUS) || (c == CH_MINUS) ||
                    (c == CH_STAR) || (c == CH_SLASH) || (c == CH_COMMA) ||
                    (c == CH_SEMI) || (c == CH_GT) || (c == CH_LT) ||
                    (c == CH_EQ) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
                    (c == CH_COLON);
    endfunction

endpackage

### rtl/tcl_in_reg.sv
// Input register that holds one accepted character beat for the classifier.
module tcl_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tcl_pkg::t_in  i_data,
    input  logic          i_take,
    output logic          o_valid,
    output tcl_pkg::t_in  o_data
);

    logic         r_valid;
    tcl_pkg::t_in r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/tcl_core.sv
// Scanner state and the token logic that turns one character into up to two tokens.
module tcl_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  tcl_pkg::t_in        i_item,
    output tcl_pkg::t_core_out  o_res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_BAD
    } t_num_phase;

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_LT,
        HELD_GT,
        HELD_COLON
    } t_held;

    logic                     r_word_open;
    logic [7:0]               r_word_len;
    logic                     r_first_digit;
    logic [1:0]               r_quotes;
    t_num_phase               r_phase;
    logic [tcl_pkg::NKW-1:0]  r_live;
    t_held                    r_held;

    logic                     n_word_open;
    logic [7:0]               n_word_len;
    logic                     n_first_digit;
    logic [1:0]               n_quotes;
    t_num_phase               n_phase;
    logic [tcl_pkg::NKW-1:0]  n_live;
    t_held                    n_held;

    function automatic logic [7:0] held_char(input t_held h);
        case (h)
            HELD_LT:    held_char = tcl_pkg::CH_LT;
            HELD_GT:    held_char = tcl_pkg::CH_GT;
            HELD_COLON: held_char = tcl_pkg::CH_COLON;
            default:    held_char = 8'h00;
        endcase
    endfunction

    function automatic t_held held_code(input logic [7:0] c);
        if (c == tcl_pkg::CH_LT) begin
            held_code = HELD_LT;
        end else if (c == tcl_pkg::CH_GT) begin
            held_code = HELD_GT;
        end else if (c == tcl_pkg::CH_COLON) begin
            held_code = HELD_COLON;
        end else begin
            held_code = HELD_NONE;
        end
    endfunction

    function automatic logic single_valid(input logic [7:0] c);
        single_valid = (c == tcl_pkg::CH_PLUS) || (c == tcl_pkg::CH_MINUS) ||
                       (c == tcl_pkg::CH_STAR) || (c == tcl_pkg::CH_SLASH) ||
                       (c == tcl_pkg::CH_GT) || (c == tcl_pkg::CH_LT) ||
                       (c == tcl_pkg::CH_EQ) || (c == tcl_pkg::CH_LPAREN) ||
                       (c == tcl_pkg::CH_RPAREN);
    endfunction

    function automatic tcl_pkg::t_out single_tok(input logic [7:0] c);
        tcl_pkg::t_out t;
        t = '0;
        t.token_class = ((c == tcl_pkg::CH_LPAREN) || (c == tcl_pkg::CH_RPAREN)) ?
                        tcl_pkg::CLS_SPECIAL : tcl_pkg::CLS_OPERATOR;
        t.first_char = c;
        single_tok = t;
    endfunction

    function automatic tcl_pkg::t_out word_tok(input logic [7:0] len,
                                               input logic [tcl_pkg::NKW-1:0] live,
                                               input t_num_phase ph,
                                               input logic [1:0] q,
                                               input logic fd);
        tcl_pkg::t_out t;
        logic          hit;
        logic [4:0]    idx;
        t   = '0;
        hit = 1'b0;
        idx = 5'd0;
        for (int k = tcl_pkg::NKW - 1; k >= 0; k--) begin
            if (live[k] && (len == {4'b0000, tcl_pkg::KW_LEN[k]})) begin
                hit = 1'b1;
                idx = 5'(k);
            end
        end
        t.word_length = len;
        if (hit) begin
            t.token_class   = tcl_pkg::CLS_RESERVED;
            t.keyword_index = idx;
        end else if ((ph == PH_INT) || (ph == PH_FRAC)) begin
            t.token_class = tcl_pkg::CLS_NUMBER;
        end else if (q == 2'd2) begin
            t.token_class = tcl_pkg::CLS_STRING;
        end else if (!fd && (q == 2'd0)) begin
            t.token_class = tcl_pkg::CLS_IDENTIFIER;
        end else begin
            t.token_class = tcl_pkg::CLS_INVALID;
        end
        word_tok = t;
    endfunction

    logic [7:0]               c;
    logic                     sym;
    logic                     dig;
    logic [7:0]               h;
    logic                     pair_rel;
    logic                     pair_asg;
    t_held                    held_mid;
    logic [7:0]               len_add;
    logic [1:0]               q_add;
    logic                     fd_add;
    t_num_phase               ph_add;
    logic [tcl_pkg::NKW-1:0]  live_add;
    logic [4:0]               cand_v;
    tcl_pkg::t_out            cand_t [5];
    logic [2:0]               n_tok;
    tcl_pkg::t_out            tok0;
    tcl_pkg::t_out            tok1;

    always_comb begin
        c = ((i_item.char_in == tcl_pkg::CH_LF) || (i_item.char_in == tcl_pkg::CH_TAB)) ?
            tcl_pkg::CH_SPACE : i_item.char_in;
        sym = tcl_pkg::is_symbol(c);
        dig = (c >= tcl_pkg::CH_ZERO) && (c <= tcl_pkg::CH_NINE);
        h   = held_char(r_held);

        pair_rel = ((r_held == HELD_LT) && ((c == tcl_pkg::CH_GT) || (c == tcl_pkg::CH_EQ))) ||
                   ((r_held == HELD_GT) && (c == tcl_pkg::CH_EQ));
        pair_asg = (r_held == HELD_COLON) && (c == tcl_pkg::CH_EQ);

        len_add = (r_word_len == 8'hFF) ? r_word_len : r_word_len + 8'd1;
        q_add   = ((c == tcl_pkg::CH_QUOTE) && (r_quotes != 2'd3)) ? r_quotes + 2'd1 : r_quotes;
        fd_add  = r_word_open ? r_first_digit : dig;
        case (r_phase)
            PH_START: ph_add = dig ? PH_INT : PH_BAD;
            PH_INT:   ph_add = dig ? PH_INT : ((c == tcl_pkg::CH_DOT) ? PH_DOT : PH_BAD);
            PH_DOT:   ph_add = dig ? PH_FRAC : PH_BAD;
            PH_FRAC:  ph_add = dig ? PH_FRAC : PH_BAD;
            default:  ph_add = PH_BAD;
        endcase
        for (int k = 0; k < tcl_pkg::NKW; k++) begin
            live_add[k] = r_live[k] && (r_word_len < {4'b0000, tcl_pkg::KW_LEN[k]}) &&
                          (tcl_pkg::kw_char(tcl_pkg::KW_TEXT[k], tcl_pkg::KW_LEN[k],
                                            r_word_len[3:0]) == c);
        end

        for (int i = 0; i < 5; i++) begin
            cand_t[i] = '0;
        end
        cand_v = '0;

        // A symbol closes the open word first.
        cand_v[0] = sym && r_word_open;
        cand_t[0] = word_tok(r_word_len, r_live, r_phase, r_quotes, r_first_digit);

        // Release of the held symbol, either paired with this character or alone.
        if (r_held != HELD_NONE) begin
            if (sym && (pair_rel || pair_asg)) begin
                cand_v[1]             = 1'b1;
                cand_t[1].token_class = pair_rel ? tcl_pkg::CLS_RELATIONAL :
                                                   tcl_pkg::CLS_ASSIGN;
                cand_t[1].first_char  = h;
                cand_t[1].second_char = c;
            end else begin
                cand_v[1] = single_valid(h);
                cand_t[1] = single_tok(h);
            end
        end

        held_mid = HELD_NONE;
        if (sym && !(pair_rel || pair_asg)) begin
            held_mid = held_code(c);
            if (held_code(c) == HELD_NONE) begin
                cand_v[2] = single_valid(c);
                cand_t[2] = single_tok(c);
            end
        end

        // At line end a newly held symbol goes out alone and the word closes.
        cand_v[3] = i_item.line_end && (held_mid != HELD_NONE) &&
                    single_valid(held_char(held_mid));
        cand_t[3] = single_tok(held_char(held_mid));
        cand_v[4] = i_item.line_end && !sym;
        cand_t[4] = word_tok(len_add, live_add, ph_add, q_add, fd_add);

        n_tok = 3'd0;
        tok0  = '0;
        tok1  = '0;
        for (int i = 0; i < 5; i++) begin
            if (cand_v[i]) begin
                if (n_tok == 3'd0) begin
                    tok0 = cand_t[i];
                end else if (n_tok == 3'd1) begin
                    tok1 = cand_t[i];
                end
                n_tok = n_tok + 3'd1;
            end
        end
        if (n_tok == 3'd1) begin
            tok0.run_last = 1'b1;
        end
        if (n_tok >= 3'd2) begin
            tok1.run_last = 1'b1;
        end
        o_res.count = (n_tok >= 3'd2) ? 2'd2 : n_tok[1:0];
        o_res.res0  = tok0;
        o_res.res1  = tok1;

        if (sym || i_item.line_end) begin
            n_word_open   = 1'b0;
            n_word_len    = 8'd0;
            n_first_digit = 1'b0;
            n_quotes      = 2'd0;
            n_phase       = PH_START;
            n_live        = '1;
        end else begin
            n_word_open   = 1'b1;
            n_word_len    = len_add;
            n_first_digit = fd_add;
            n_quotes      = q_add;
            n_phase       = ph_add;
            n_live        = live_add;
        end
        n_held = i_item.line_end ? HELD_NONE : held_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_open   <= 1'b0;
            r_word_len    <= 8'd0;
            r_first_digit <= 1'b0;
            r_quotes      <= 2'd0;
            r_phase       <= PH_START;
            r_live        <= '1;
            r_held        <= HELD_NONE;
        end else if (i_step) begin
            r_word_open   <= n_word_open;
            r_word_len    <= n_word_len;
            r_first_digit <= n_first_digit;
            r_quotes      <= n_quotes;
            r_phase       <= n_phase;
            r_live        <= n_live;
            r_held        <= n_held;
        end
    end

endmodule

### rtl/tcl_out_buf.sv
// Two-entry result register that delivers the tokens of one character in order.
module tcl_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tcl_pkg::t_core_out  i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output tcl_pkg::t_out       o_data
);

    logic [1:0]    r_cnt;
    tcl_pkg::t_out r_slot0;
    tcl_pkg::t_out r_slot1;
    logic          pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot0;
    assign pop     = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_res.res0;
            r_slot1 <= i_res.res1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

### rtl/token_classifier_lexer.sv
// Top level of the token classifier: input register, scanner core and result register.
// One character beat gives zero, one or two token beats; the character is held in the input
// register and its tokens in the result register. The scanner state and the result register load
// together, so characters stream at one per cycle as long as each yields at most one token and
// the output is ready; a character that yields two tokens holds the input while the two-entry
// result register drains. Words are classed as reserved word, number, string, identifier or
// invalid when they close; '<', '>' and ':' wait one character to pair into relational or
// assignment tokens. Token text is not carried, only the length (saturated at 255) and keyword index.
module token_classifier_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcl_pkg::t_out o_out_data
);

    logic               item_valid;
    tcl_pkg::t_in       item;
    logic               buf_free;
    logic               step;
    tcl_pkg::t_core_out core_res;

    assign step = item_valid && buf_free;

    tcl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_take  (step),
        .o_valid (item_valid),
        .o_data  (item)
    );

    tcl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (item),
        .o_res   (core_res)
    );

    tcl_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (core_res),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
